[rtl/gn3_pkg.sv]
// Shared types and constants for the 3-D gradient noise block.
// No dependencies.
package gn3_pkg;

    localparam int COORD_W = 32;
    localparam int BYTE_W  = 8;
    localparam int OUT_W   = 19;

    // permutation table depth; indices wrap by masking, so it stays a power of two
    localparam int TABLE_SIZE = 256;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // output saturation bound, Q2.16
    localparam longint OUT_MAX = 131072;

    // gradient selection thresholds on the low hash nibble
    localparam logic [3:0] GRAD_U_SPLIT = 4'd8;
    localparam logic [3:0] GRAD_V_SPLIT = 4'd4;
    localparam logic [3:0] GRAD_V_X_A   = 4'd12;
    localparam logic [3:0] GRAD_V_X_B   = 4'd14;

endpackage

[rtl/gn3_if.sv]
// Request and response channel interfaces for the gradient noise block.
// Depends on gn3_pkg for field widths.
interface gn3_req_if
    import gn3_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [BYTE_W-1:0]         table_index;
    logic [BYTE_W-1:0]         table_value;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (output valid, req_type, table_index, table_value,
                    coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, req_type, table_index, table_value,
                    coord_x, coord_y, coord_z, output ready);
endinterface

interface gn3_rsp_if
    import gn3_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

[rtl/gradient_noise_3d.sv]
// Top level of the 3-D gradient noise block: table copies, hash and fade
// pipeline, trilinear blend and output register. Depends on gn3_pkg, gn3_if.
//
// One transaction is accepted per cycle while the output can move; a result
// reaches the output register after its evaluate transaction has passed the
// stage registers. The 256-byte permutation table is held in seven replicated
// synchronous memories (one for the cell row, two for the second hash level,
// four for the corner level), so all fourteen lookups of a point proceed in
// flight each cycle; a table write travels down the pipeline and updates each
// copy in order with the evaluations around it. Stalls come only from the
// response side. The table is not cleared at reset: evaluate only after its
// entries are written.
module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    gn3_req_if.sink   req,
    gn3_rsp_if.source rsp
);

    localparam int FB    = FRACTION_BITS;
    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int NST   = 9;
    localparam int NCOPY = 7;
    localparam int PW    = 2 * FB + 6;
    localparam int AW    = FB + 5;
    localparam int GW    = FB + 3;
    localparam int UP    = (FB < 16) ? 16 - FB : 0;
    localparam int DN    = (FB > 16) ? FB - 16 : 0;
    localparam longint ONE     = longint'(1) << FB;
    localparam longint HALF_DN = (DN > 0) ? (longint'(1) << (DN - 1)) : 0;

    localparam int CP_X  = 0;
    localparam int CP_A  = 1;
    localparam int CP_B  = 2;
    localparam int CP_AA = 3;
    localparam int CP_AB = 4;
    localparam int CP_BA = 5;
    localparam int CP_BB = 6;

    localparam logic signed [AW-1:0]   FIFTEEN = AW'(15 * ONE);
    localparam logic signed [AW-1:0]   TEN     = AW'(10 * ONE);
    localparam logic signed [FB+1:0]   ONE_O   = (FB+2)'(ONE);
    localparam logic signed [PW-1:0]   HALF_P  = PW'(ONE / 2);

    typedef struct {
        logic                 wr;
        logic [IW-1:0]        widx;
        logic [BYTE_W-1:0]    wdat;
        logic [IW-1:0]        cx;
        logic [IW-1:0]        cy;
        logic [IW-1:0]        cz;
        logic [FB-1:0]        f    [3];
        logic signed [AW-1:0] acc  [3];
        logic signed [PW-1:0] pm   [3];
        logic signed [GW-1:0] g    [8];
        logic [FB:0]          fade [3];
        logic signed [PW-1:0] lp   [4];
        logic signed [GW-1:0] lv   [4];
    } stage_t;

    function automatic logic [IW-1:0] to_idx(input logic [BYTE_W-1:0] v);
        logic [IW+BYTE_W-1:0] t;
        t = {{IW{1'b0}}, v};
        return t[IW-1:0];
    endfunction

    function automatic logic signed [FB+5:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + HALF_P) >>> FB;
        return (FB+6)'(s);
    endfunction

    function automatic logic signed [GW-1:0] grad(input logic [BYTE_W-1:0] hash,
                                                  input logic signed [FB+1:0] x,
                                                  input logic signed [FB+1:0] y,
                                                  input logic signed [FB+1:0] z);
        logic [3:0]           h;
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        h = hash[3:0];
        u = (h < GRAD_U_SPLIT) ? GW'(x) : GW'(y);
        if (h < GRAD_V_SPLIT)
            v = GW'(y);
        else if (h == GRAD_V_X_A || h == GRAD_V_X_B)
            v = GW'(x);
        else
            v = GW'(z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [GW-1:0] lerp_fin(input logic signed [GW-1:0] a,
                                                      input logic signed [PW-1:0] p);
        logic signed [FB+5:0] s;
        s = (FB+6)'(a) + rnd(p);
        return GW'(s);
    endfunction

    function automatic logic signed [PW-1:0] lerp_mul(input logic [FB:0] t,
                                                      input logic signed [GW-1:0] a,
                                                      input logic signed [GW-1:0] b);
        logic signed [FB+3:0] d;
        logic signed [PW-1:0] pr;
        d  = (FB+4)'(b) - (FB+4)'(a);
        pr = $signed({1'b0, t}) * d;
        return pr;
    endfunction

    stage_t          pipe_reg  [1:NST];
    stage_t          pipe_next [1:NST];
    logic [NST:1]    vld_reg;
    logic            en;
    logic            rsp_valid_reg;
    logic signed [OUT_W-1:0] noise_reg;
    logic signed [OUT_W-1:0] noise_next;

    logic              wr_en   [NCOPY];
    logic [IW-1:0]     wr_addr [NCOPY];
    logic [BYTE_W-1:0] wr_dat  [NCOPY];
    logic [IW-1:0]     rd_addr [NCOPY][2];
    logic [BYTE_W-1:0] rd_reg  [NCOPY][2];

    assign en        = !rsp_valid_reg || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.noise_value = noise_reg;

    // table copies
    for (genvar c = 0; c < NCOPY; c++) begin : g_copy
        logic [BYTE_W-1:0] mem [TABLE_SIZE];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wr_en[c])
                    mem[wr_addr[c]] <= wr_dat[c];
                rd_reg[c][0] <= mem[rd_addr[c][0]];
                rd_reg[c][1] <= mem[rd_addr[c][1]];
            end
        end
    end

    always_comb
    begin
        logic signed [63:0]       cxe;
        logic signed [63:0]       cye;
        logic signed [63:0]       cze;
        logic [IW-1:0]            a;
        logic [IW-1:0]            b;
        logic [IW-1:0]            aa;
        logic [IW-1:0]            ab;
        logic [IW-1:0]            ba;
        logic [IW-1:0]            bb;
        logic signed [FB+1:0]     x0;
        logic signed [FB+1:0]     y0;
        logic signed [FB+1:0]     z0;
        logic signed [FB+1:0]     x1;
        logic signed [FB+1:0]     y1;
        logic signed [FB+1:0]     z1;
        logic signed [FB+5:0]     r;
        logic signed [GW-1:0]     l   [4];
        logic signed [GW-1:0]     fin;
        logic signed [47:0]       e;
        logic signed [47:0]       conv;

        // stage 1: split coordinates, first fade term, row lookup
        cxe = 64'(req.coord_x);
        cye = 64'(req.coord_y);
        cze = 64'(req.coord_z);
        pipe_next[1]      = pipe_reg[1];
        pipe_next[1].wr   = (req.req_type == REQ_WRITE);
        pipe_next[1].widx = to_idx(req.table_index);
        pipe_next[1].wdat = req.table_value;
        pipe_next[1].cx   = cxe[FB +: IW];
        pipe_next[1].cy   = cye[FB +: IW];
        pipe_next[1].cz   = cze[FB +: IW];
        pipe_next[1].f[0] = cxe[FB-1:0];
        pipe_next[1].f[1] = cye[FB-1:0];
        pipe_next[1].f[2] = cze[FB-1:0];
        for (int i = 0; i < 3; i++)
            pipe_next[1].acc[i] = $signed({4'b0, pipe_next[1].f[i]}) * $signed(AW'(6))
                                  - FIFTEEN;
        wr_en[CP_X]      = req.valid && (req.req_type == REQ_WRITE);
        wr_addr[CP_X]    = pipe_next[1].widx;
        wr_dat[CP_X]     = req.table_value;
        rd_addr[CP_X][0] = pipe_next[1].cx;
        rd_addr[CP_X][1] = pipe_next[1].cx + IW'(1);

        // stage 2: first hash level
        pipe_next[2] = pipe_reg[1];
        for (int i = 0; i < 3; i++)
            pipe_next[2].pm[i] = $signed({1'b0, pipe_reg[1].f[i]}) * pipe_reg[1].acc[i];
        a = to_idx(rd_reg[CP_X][0]) + pipe_reg[1].cy;
        b = to_idx(rd_reg[CP_X][1]) + pipe_reg[1].cy;
        rd_addr[CP_A][0] = a;
        rd_addr[CP_A][1] = a + IW'(1);
        rd_addr[CP_B][0] = b;
        rd_addr[CP_B][1] = b + IW'(1);
        for (int c = CP_A; c <= CP_B; c++)
        begin
            wr_en[c]   = vld_reg[1] && pipe_reg[1].wr;
            wr_addr[c] = pipe_reg[1].widx;
            wr_dat[c]  = pipe_reg[1].wdat;
        end

        // stage 3: corner hash level
        pipe_next[3] = pipe_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[3].acc[i] = AW'(rnd(pipe_reg[2].pm[i])) + TEN;
            pipe_next[3].pm[i]  = $signed({1'b0, pipe_reg[2].f[i]}) * pipe_next[3].acc[i];
        end
        aa = to_idx(rd_reg[CP_A][0]) + pipe_reg[2].cz;
        ab = to_idx(rd_reg[CP_A][1]) + pipe_reg[2].cz;
        ba = to_idx(rd_reg[CP_B][0]) + pipe_reg[2].cz;
        bb = to_idx(rd_reg[CP_B][1]) + pipe_reg[2].cz;
        rd_addr[CP_AA][0] = aa;
        rd_addr[CP_AA][1] = aa + IW'(1);
        rd_addr[CP_AB][0] = ab;
        rd_addr[CP_AB][1] = ab + IW'(1);
        rd_addr[CP_BA][0] = ba;
        rd_addr[CP_BA][1] = ba + IW'(1);
        rd_addr[CP_BB][0] = bb;
        rd_addr[CP_BB][1] = bb + IW'(1);
        for (int c = CP_AA; c <= CP_BB; c++)
        begin
            wr_en[c]   = vld_reg[2] && pipe_reg[2].wr;
            wr_addr[c] = pipe_reg[2].widx;
            wr_dat[c]  = pipe_reg[2].wdat;
        end

        // stage 4: corner gradients
        pipe_next[4] = pipe_reg[3];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[4].acc[i] = AW'(rnd(pipe_reg[3].pm[i]));
            pipe_next[4].pm[i]  = $signed({1'b0, pipe_reg[3].f[i]}) * pipe_next[4].acc[i];
        end
        x0 = $signed({2'b0, pipe_reg[3].f[0]});
        y0 = $signed({2'b0, pipe_reg[3].f[1]});
        z0 = $signed({2'b0, pipe_reg[3].f[2]});
        x1 = x0 - ONE_O;
        y1 = y0 - ONE_O;
        z1 = z0 - ONE_O;
        pipe_next[4].g[0] = grad(rd_reg[CP_AA][0], x0, y0, z0);
        pipe_next[4].g[1] = grad(rd_reg[CP_BA][0], x1, y0, z0);
        pipe_next[4].g[2] = grad(rd_reg[CP_AB][0], x0, y1, z0);
        pipe_next[4].g[3] = grad(rd_reg[CP_BB][0], x1, y1, z0);
        pipe_next[4].g[4] = grad(rd_reg[CP_AA][1], x0, y0, z1);
        pipe_next[4].g[5] = grad(rd_reg[CP_BA][1], x1, y0, z1);
        pipe_next[4].g[6] = grad(rd_reg[CP_AB][1], x0, y1, z1);
        pipe_next[4].g[7] = grad(rd_reg[CP_BB][1], x1, y1, z1);

        // stage 5: last fade product
        pipe_next[5] = pipe_reg[4];
        for (int i = 0; i < 3; i++)
        begin
            pipe_next[5].acc[i] = AW'(rnd(pipe_reg[4].pm[i]));
            pipe_next[5].pm[i]  = $signed({1'b0, pipe_reg[4].f[i]}) * pipe_next[5].acc[i];
        end

        // stage 6: fade clamp to [0, 1]
        pipe_next[6] = pipe_reg[5];
        for (int i = 0; i < 3; i++)
        begin
            r = rnd(pipe_reg[5].pm[i]);
            if (r < 0)
                pipe_next[6].fade[i] = '0;
            else if (r > (FB+6)'(ONE))
                pipe_next[6].fade[i] = (FB+1)'(ONE);
            else
                pipe_next[6].fade[i] = r[FB:0];
        end

        // stage 7: x products
        pipe_next[7] = pipe_reg[6];
        for (int i = 0; i < 4; i++)
        begin
            pipe_next[7].lp[i] = lerp_mul(pipe_reg[6].fade[0], pipe_reg[6].g[2*i],
                                          pipe_reg[6].g[2*i+1]);
            pipe_next[7].lv[i] = pipe_reg[6].g[2*i];
        end

        // stage 8: x results, y products
        pipe_next[8] = pipe_reg[7];
        for (int i = 0; i < 4; i++)
            l[i] = lerp_fin(pipe_reg[7].lv[i], pipe_reg[7].lp[i]);
        pipe_next[8].lp[0] = lerp_mul(pipe_reg[7].fade[1], l[0], l[1]);
        pipe_next[8].lv[0] = l[0];
        pipe_next[8].lp[1] = lerp_mul(pipe_reg[7].fade[1], l[2], l[3]);
        pipe_next[8].lv[1] = l[2];

        // stage 9: y results, z product
        pipe_next[9] = pipe_reg[8];
        l[0] = lerp_fin(pipe_reg[8].lv[0], pipe_reg[8].lp[0]);
        l[1] = lerp_fin(pipe_reg[8].lv[1], pipe_reg[8].lp[1]);
        pipe_next[9].lp[0] = lerp_mul(pipe_reg[8].fade[2], l[0], l[1]);
        pipe_next[9].lv[0] = l[0];

        // output: z result, rescale to 16 fraction bits, saturate
        fin  = lerp_fin(pipe_reg[9].lv[0], pipe_reg[9].lp[0]);
        e    = 48'(fin);
        conv = ((e <<< UP) + 48'(HALF_DN)) >>> DN;
        if (conv > 48'(OUT_MAX))
            noise_next = OUT_W'(OUT_MAX);
        else if (conv < -48'(OUT_MAX))
            noise_next = -OUT_W'(OUT_MAX);
        else
            noise_next = OUT_W'(conv);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= NST; k++)
                pipe_reg[k] <= pipe_next[k];
            noise_reg <= noise_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NST-1:1], req.valid};
            rsp_valid_reg <= vld_reg[NST] && !pipe_reg[NST].wr;
        end
    end

    // checks
    a_out_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> rsp_valid_reg == $past(vld_reg[NST] && !pipe_reg[NST].wr))
        else $error("response valid does not match last stage");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[NST] && pipe_reg[NST].wr) |=> !rsp_valid_reg)
        else $error("table write produced a response");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[6] && !pipe_reg[6].wr) |->
            (pipe_reg[6].fade[0] <= (FB+1)'(ONE) && pipe_reg[6].fade[1] <= (FB+1)'(ONE)
             && pipe_reg[6].fade[2] <= (FB+1)'(ONE)))
        else $error("fade out of range");

endmodule

[sim/tb_gradient_noise_3d.sv]
// Self-checking testbench for gradient_noise_3d: table writes, then evaluations checked
// against an in-bench fixed-point noise predictor. Depends on gn3_pkg, gn3_if and the RTL.
module tb_gradient_noise_3d;
    import gn3_pkg::*;

    localparam int  TSIZE = 256;
    localparam int  FRAC  = 16;
    localparam longint ONE_FX = 64'sd1 <<< FRAC;
    localparam int  LIMIT = 400000;

    typedef struct {
        logic        kind;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        has_exp;
        logic [18:0] exp_val;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    gn3_req_if req ();
    gn3_rsp_if rsp ();

    gradient_noise_3d dut (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [7:0]  perm [TSIZE];
    logic [18:0] noise_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_off = 1'b0;
    stim_t       directed [$];

    function automatic longint rnd_sh(longint v);
        longint s;
        s = v + (ONE_FX >>> 1);
        return s >>> FRAC;
    endfunction

    function automatic longint fade(longint f);
        longint a, b, c, d, r;
        a = 6 * f - 15 * ONE_FX;
        b = rnd_sh(f * a) + 10 * ONE_FX;
        c = rnd_sh(f * b);
        d = rnd_sh(f * c);
        r = rnd_sh(f * d);
        if (r < 0) r = 0;
        if (r > ONE_FX) r = ONE_FX;
        return r;
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + rnd_sh(t * (b - a));
    endfunction

    function automatic longint grad(logic [7:0] hv, longint x, longint y, longint z);
        logic [3:0] h;
        longint u, v;
        h = hv[3:0];
        u = (h < GRAD_U_SPLIT) ? x : y;
        v = (h < GRAD_V_SPLIT) ? y : ((h == GRAD_V_X_A || h == GRAD_V_X_B) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic [7:0] pt(int i);
        return perm[i % TSIZE];
    endfunction

    function automatic logic [18:0] predict_noise(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
        int cx, cy, cz, a, aa, ab, b, ba, bb;
        longint x, y, z, u, v, w, x1, y1, z1, r;
        cx = px[23:16]; cy = py[23:16]; cz = pz[23:16];
        x = px[15:0]; y = py[15:0]; z = pz[15:0];
        u = fade(x); v = fade(y); w = fade(z);
        a  = (pt(cx) + cy) % TSIZE;
        aa = (pt(a) + cz) % TSIZE;
        ab = (pt(a + 1) + cz) % TSIZE;
        b  = (pt(cx + 1) + cy) % TSIZE;
        ba = (pt(b) + cz) % TSIZE;
        bb = (pt(b + 1) + cz) % TSIZE;
        x1 = x - ONE_FX; y1 = y - ONE_FX; z1 = z - ONE_FX;
        r = blend(w,
                blend(v,
                    blend(u, grad(pt(aa), x, y, z), grad(pt(ba), x1, y, z)),
                    blend(u, grad(pt(ab), x, y1, z), grad(pt(bb), x1, y1, z))),
                blend(v,
                    blend(u, grad(pt(aa + 1), x, y, z1), grad(pt(ba + 1), x1, y, z1)),
                    blend(u, grad(pt(ab + 1), x, y1, z1), grad(pt(bb + 1), x1, y1, z1))));
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < -OUT_MAX) r = -OUT_MAX;
        return r[18:0];
    endfunction

    function automatic stim_t mk_write(int i, int v);
        stim_t s;
        s = '{REQ_WRITE, i[7:0], v[7:0], 0, 0, 0, 1'b0, 0};
        // random junk on unused coordinate fields
        s.x = $urandom; s.y = $urandom; s.z = $urandom;
        return s;
    endfunction

    function automatic stim_t mk_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        stim_t s;
        s = '{REQ_EVAL, 0, 0, x, y, z, 1'b0, 0};
        s.idx = $urandom; s.val = $urandom;
        return s;
    endfunction

    // valid stays high across a zero gap so it never gets two updates in one step
    task automatic send(stim_t s);
        int gap;
        gap = hold_off ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= s.kind;
        req.table_index <= s.idx;
        req.table_value <= s.val;
        req.coord_x     <= s.x;
        req.coord_y     <= s.y;
        req.coord_z     <= s.z;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        // transaction accepted at this edge: update predictor in order
        if (s.kind == REQ_WRITE)
            perm[s.idx] = s.val;
        else
            noise_q.push_back(s.has_exp ? s.exp_val : predict_noise(s.x, s.y, s.z));
    endtask

    // response side: random stalls plus one long hold-off
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (noise_q.size() == 0)
            begin
                $display("%0t: unexpected noise result %0d", $time, $signed(rsp.noise_value));
                errors++;
            end
            else
            begin
                logic [18:0] want;
                want = noise_q.pop_front();
                if (rsp.noise_value !== want)
                begin
                    $display("%0t: noise_value expected %0d actual %0d", $time,
                             $signed(want), $signed(rsp.noise_value));
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_gradient_noise_3d failed");
            $finish;
        end
    end

    initial
    begin
        stim_t s;
        int n_rand;
        req.valid = 1'b0; req.req_type = REQ_WRITE; req.table_index = '0;
        req.table_value = '0; req.coord_x = '0; req.coord_y = '0; req.coord_z = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero table: every gradient at the origin corner is zero
        for (int i = 0; i < TSIZE; i++)
            send(mk_write(i, 0));
        s = mk_eval(32'h0, 32'h0, 32'h0); s.has_exp = 1'b1; s.exp_val = '0;
        directed.push_back(s);
        directed.push_back(mk_eval(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        directed.push_back(mk_eval(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF));
        directed.push_back(mk_write(255, 255));
        directed.push_back(mk_write(0, 15));
        directed.push_back(mk_eval(32'h00FF_8000, 32'h00FF_0000, 32'h00FF_FFFF));
        directed.push_back(mk_eval(32'hFFFF_0001, 32'h0001_8000, 32'h0000_0001));
        for (int h = 0; h < 16; h++)
            directed.push_back(mk_write(h * 16 + 1, h * 17));
        directed.push_back(mk_eval(32'h0000_C000, 32'h0000_4000, 32'h0000_8000));
        foreach (directed[i])
            send(directed[i]);

        // mostly evaluations, with random table writes mixed in
        n_rand = 0;
        while (n_rand < 1620)
        begin
            if ($urandom_range(0, 9) == 0)
                s = mk_write($urandom_range(0, 255), $urandom_range(0, 255));
            else if ($urandom_range(0, 1) == 0)
                s = mk_eval($urandom, $urandom, $urandom);
            else
                s = mk_eval({16'($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 3)),
                             16'($urandom)}, $urandom, {24'($urandom), 8'h00});
            if (n_rand == 600)
                hold_off = 1'b1;
            send(s);
            n_rand++;
        end
        req.valid <= 1'b0;
        while (noise_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("tb_gradient_noise_3d passed");
        else
            $display("tb_gradient_noise_3d failed");
        $finish;
    end
endmodule

[files.f]
rtl/gn3_pkg.sv
rtl/gn3_if.sv
rtl/gradient_noise_3d.sv
sim/tb_gradient_noise_3d.sv
